// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the converter's RTL modules.
// Both need clock aclk in scope; I2P_ASSERT also needs the active-low reset aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define I2P_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define I2P_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/i2p_pkg.sv -----
// Shared types, codes and lookup functions for the infix-to-postfix converter.
// No dependencies; every RTL module imports this package.
package i2p_pkg;

    localparam int I2P_STACK_DEPTH = 32;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;

    localparam logic [2:0] CODE_OPEN = 3'd0;
    localparam logic [2:0] CODE_ADD  = 3'd1;
    localparam logic [2:0] CODE_SUB  = 3'd2;
    localparam logic [2:0] CODE_MUL  = 3'd3;
    localparam logic [2:0] CODE_DIV  = 3'd4;
    localparam logic [2:0] CODE_POW  = 3'd5;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
    localparam logic [1:0] ERR_UNMATCHED = 2'd2;

    typedef enum logic [2:0] {
        K_IGNORE,
        K_LETTER,
        K_OPEN,
        K_CLOSE,
        K_OP
    } i2p_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_OP,
        ST_CLOSE,
        ST_FLUSH,
        ST_DONE
    } i2p_state_t;

    typedef struct packed {
        i2p_kind_t  kind;
        logic [2:0] code;
        logic [7:0] ch;
        logic       is_end;
    } i2p_item_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [2:0] code;
    } i2p_stk_cmd_t;

    typedef struct packed {
        logic       empty;
        logic       full;
        logic [2:0] top;
    } i2p_stk_stat_t;

    function automatic logic [2:0] op_code(input logic [7:0] c);
        logic [2:0] r;
        case (c)
            CH_PLUS:  r = CODE_ADD;
            CH_MINUS: r = CODE_SUB;
            CH_STAR:  r = CODE_MUL;
            CH_SLASH: r = CODE_DIV;
            CH_CARET: r = CODE_POW;
            default:  r = CODE_OPEN;
        endcase
        return r;
    endfunction

    function automatic i2p_kind_t classify(input logic [7:0] c);
        i2p_kind_t k;
        if ((c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z)) begin
            k = K_LETTER;
        end else if (c == CH_OPEN) begin
            k = K_OPEN;
        end else if (op_code(c) != CODE_OPEN) begin
            k = K_OP;
        end else if (c == CH_CLOSE) begin
            k = K_CLOSE;
        end else begin
            k = K_IGNORE;
        end
        return k;
    endfunction

    function automatic logic [7:0] code_char(input logic [2:0] code);
        logic [7:0] r;
        case (code)
            CODE_OPEN: r = CH_OPEN;
            CODE_ADD:  r = CH_PLUS;
            CODE_SUB:  r = CH_MINUS;
            CODE_MUL:  r = CH_STAR;
            CODE_DIV:  r = CH_SLASH;
            CODE_POW:  r = CH_CARET;
            default:   r = 8'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] code_prec(input logic [2:0] code);
        logic [1:0] r;
        case (code) inside
            CODE_ADD, CODE_SUB: r = 2'd1;
            CODE_MUL, CODE_DIV: r = 2'd2;
            CODE_POW:           r = 2'd3;
            default:            r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- hw/rtl/infix_to_postfix_converter.sv -----
// Infix-to-postfix converter (shunting-yard), one ASCII character per input request.
// The input channel (s_valid, s_ready, s_char_in, s_is_end) takes one character; s_is_end
// marks the last character of an expression, after which the operator stack is flushed.
// The result channel (m_valid, m_ready, m_out_char, m_has_char, m_is_last, m_error)
// returns postfix characters; the final result of an end request carries m_is_last, and
// an error code (overflow or unmatched parenthesis) rides on the last result of a request.
// A two-entry queue decouples the classifier from the sequencer, so requests are taken
// while the sequencer works. A letter, an ignored character or a '(' pops no stack entry;
// an operator, or a ')' without its '(', pops k entries, and a ')' that finds its '('
// pops k entries and then the '(' itself. An end request then flushes the remaining
// entries. The pops go through the operator stack memory at one per cycle while the
// result register can take a result.
// Synchronous reset empties the queue and the stack and drops any pending result. When the
// receiver holds m_ready low, the result register keeps its request and the sequencer
// waits; the queue then fills and s_ready falls.
// Depends on i2p_pkg, i2p_front, i2p_stack and i2p_back.
module infix_to_postfix_converter import i2p_pkg::*; #(
    parameter int STACK_DEPTH = I2P_STACK_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_in,
    input  logic       s_is_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_has_char,
    output logic       m_is_last,
    output logic [1:0] m_error
);

    logic          q_valid;
    logic          q_pop;
    i2p_item_t     q_item;
    i2p_stk_cmd_t  stk_cmd;
    i2p_stk_stat_t stk_stat;

    i2p_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_char_in (s_char_in),
        .s_is_end  (s_is_end),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    i2p_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (stk_cmd),
        .stat    (stk_stat)
    );

    i2p_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .stk_cmd    (stk_cmd),
        .stk_stat   (stk_stat),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_has_char (m_has_char),
        .m_is_last  (m_is_last),
        .m_error    (m_error)
    );

endmodule

// ----- hw/rtl/i2p_front.sv -----
// Front end of the converter: classifies each accepted character and queues it.
// Depends on i2p_pkg and assert_macros.svh.
`include "assert_macros.svh"

module i2p_front import i2p_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic [7:0] s_char_in,
    input  logic      s_is_end,
    output logic      q_valid,
    output i2p_item_t q_item,
    input  logic      q_pop
);

    i2p_item_t  q_mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    i2p_item_t  item_in;

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = q_mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;

    always_comb begin
        item_in.kind   = classify(s_char_in);
        item_in.code   = op_code(s_char_in);
        item_in.ch     = s_char_in;
        item_in.is_end = s_is_end;
    end

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= item_in;
        end
    end

    `I2P_ASSERT(a_queue_bound, cnt_reg != 2'd3, "Item queue holds more than two entries.")
    `I2P_ASSERT(a_pop_nonempty, q_pop |-> q_valid, "Item queue popped while empty.")

endmodule

// ----- hw/rtl/i2p_stack.sv -----
// Operator stack of the converter: top entry in a register, the rest in a memory
// with a registered read of the entry below the top. Depends on i2p_pkg and assert_macros.svh.
`include "assert_macros.svh"

module i2p_stack import i2p_pkg::*; #(
    parameter int STACK_DEPTH = I2P_STACK_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  i2p_stk_cmd_t  cmd,
    output i2p_stk_stat_t stat
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [2:0]    mem [STACK_DEPTH];
    logic [CW-1:0] count_reg, count_next;
    logic [2:0]    top_reg, top_next;
    logic [2:0]    below_reg;
    logic [CW-1:0] wr_count, rd_count;
    logic [AW-1:0] wr_addr, rd_addr;
    logic          wr_en;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CW'(STACK_DEPTH));
    assign stat.top   = top_reg;

    always_comb begin
        count_next = count_reg;
        top_next   = top_reg;
        wr_en      = 1'b0;
        if (cmd.push) begin
            count_next = count_reg + CW'(1);
            top_next   = cmd.code;
            wr_en      = (count_reg != '0);
        end else if (cmd.pop) begin
            count_next = count_reg - CW'(1);
            top_next   = below_reg;
        end
        wr_count = count_reg - CW'(1);
        rd_count = count_next - CW'(2);
        wr_addr  = wr_count[AW-1:0];
        rd_addr  = rd_count[AW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg <= top_next;
        if (wr_en) begin
            mem[wr_addr] <= top_reg;
        end
        if (wr_en && (wr_addr == rd_addr)) begin
            below_reg <= top_reg;
        end else begin
            below_reg <= mem[rd_addr];
        end
    end

    `I2P_ASSERT(a_push_room, cmd.push |-> !stat.full, "Push issued to a full operator stack.")
    `I2P_ASSERT(a_pop_data, cmd.pop |-> !stat.empty && !cmd.push,
        "Pop issued to an empty stack or together with a push.")

endmodule

// ----- hw/rtl/i2p_back.sv -----
// Back end of the converter: runs the shunting-yard steps on queued items, one stack operation
// per cycle if the result register is free; holds it. Depends on i2p_pkg and assert_macros.svh.
`include "assert_macros.svh"

module i2p_back import i2p_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    input  i2p_item_t     q_item,
    output logic          q_pop,
    output i2p_stk_cmd_t  stk_cmd,
    input  i2p_stk_stat_t stk_stat,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_out_char,
    output logic          m_has_char,
    output logic          m_is_last,
    output logic [1:0]    m_error
);

    i2p_state_t st_reg, st_next;
    logic [2:0] code_reg, code_next;
    logic       end_reg, end_next;
    logic [1:0] err_reg, err_next;
    logic       pend_valid_reg, pend_valid_next;
    logic [7:0] pend_char_reg, pend_char_next;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_char_reg, m_char_next;
    logic       m_has_reg, m_has_next;
    logic       m_last_reg, m_last_next;
    logic [1:0] m_err_reg, m_err_next;

    logic       out_free;
    logic       out_load;
    logic [7:0] out_char;
    logic       out_has;
    logic       out_last;
    logic [1:0] out_err;
    logic       gen_valid;
    logic [7:0] gen_char;
    logic       top_binds;

    assign out_free   = !m_valid_reg || m_ready;
    assign m_valid    = m_valid_reg;
    assign m_out_char = m_char_reg;
    assign m_has_char = m_has_reg;
    assign m_is_last  = m_last_reg;
    assign m_error    = m_err_reg;

    assign top_binds = !stk_stat.empty && (stk_stat.top != CODE_OPEN)
                       && (code_prec(stk_stat.top) >= code_prec(code_reg));

    always_comb begin
        st_next         = st_reg;
        code_next       = code_reg;
        end_next        = end_reg;
        err_next        = err_reg;
        pend_valid_next = pend_valid_reg;
        pend_char_next  = pend_char_reg;
        q_pop           = 1'b0;
        stk_cmd         = '0;
        out_load        = 1'b0;
        out_char        = 8'd0;
        out_has         = 1'b0;
        out_last        = 1'b0;
        out_err         = ERR_NONE;
        gen_valid       = 1'b0;
        gen_char        = 8'd0;

        if (out_free) begin
            unique case (st_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        q_pop     = 1'b1;
                        end_next  = q_item.is_end;
                        err_next  = ERR_NONE;
                        code_next = q_item.code;
                        unique case (q_item.kind)
                            K_LETTER: begin
                                if (q_item.is_end) begin
                                    gen_valid = 1'b1;
                                    gen_char  = q_item.ch;
                                    st_next   = ST_FLUSH;
                                end else begin
                                    out_load = 1'b1;
                                    out_char = q_item.ch;
                                    out_has  = 1'b1;
                                end
                            end
                            K_OPEN: begin
                                if (stk_stat.full) begin
                                    err_next = ERR_OVERFLOW;
                                end else begin
                                    stk_cmd.push = 1'b1;
                                    stk_cmd.code = CODE_OPEN;
                                end
                                st_next = q_item.is_end ? ST_FLUSH : ST_DONE;
                            end
                            K_OP: begin
                                st_next = ST_POP_OP;
                            end
                            K_CLOSE: begin
                                st_next = ST_CLOSE;
                            end
                            default: begin
                                st_next = q_item.is_end ? ST_FLUSH : ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_POP_OP: begin
                    if (top_binds) begin
                        stk_cmd.pop = 1'b1;
                        gen_valid   = 1'b1;
                        gen_char    = code_char(stk_stat.top);
                    end else begin
                        if (stk_stat.full) begin
                            err_next = (err_reg == ERR_NONE) ? ERR_OVERFLOW : err_reg;
                        end else begin
                            stk_cmd.push = 1'b1;
                            stk_cmd.code = code_reg;
                        end
                        st_next = end_reg ? ST_FLUSH : ST_DONE;
                    end
                end
                ST_CLOSE: begin
                    if (stk_stat.empty) begin
                        err_next = (err_reg == ERR_NONE) ? ERR_UNMATCHED : err_reg;
                        st_next  = end_reg ? ST_FLUSH : ST_DONE;
                    end else begin
                        stk_cmd.pop = 1'b1;
                        if (stk_stat.top == CODE_OPEN) begin
                            st_next = end_reg ? ST_FLUSH : ST_DONE;
                        end else begin
                            gen_valid = 1'b1;
                            gen_char  = code_char(stk_stat.top);
                        end
                    end
                end
                ST_FLUSH: begin
                    if (stk_stat.empty) begin
                        st_next = ST_DONE;
                    end else begin
                        stk_cmd.pop = 1'b1;
                        if (stk_stat.top == CODE_OPEN) begin
                            err_next = (err_reg == ERR_NONE) ? ERR_UNMATCHED : err_reg;
                        end else begin
                            gen_valid = 1'b1;
                            gen_char  = code_char(stk_stat.top);
                        end
                    end
                end
                ST_DONE: begin
                    if (pend_valid_reg) begin
                        out_load = 1'b1;
                        out_char = pend_char_reg;
                        out_has  = 1'b1;
                        out_last = end_reg;
                        out_err  = err_reg;
                    end else if (end_reg || (err_reg != ERR_NONE)) begin
                        out_load = 1'b1;
                        out_last = end_reg;
                        out_err  = err_reg;
                    end
                    pend_valid_next = 1'b0;
                    st_next         = ST_IDLE;
                end
                default: begin
                    st_next = ST_IDLE;
                end
            endcase

            // A new character sends the held one on, since it can no longer be the last.
            if (gen_valid) begin
                if (pend_valid_reg) begin
                    out_load = 1'b1;
                    out_char = pend_char_reg;
                    out_has  = 1'b1;
                end
                pend_valid_next = 1'b1;
                pend_char_next  = gen_char;
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_char_next  = m_char_reg;
        m_has_next   = m_has_reg;
        m_last_next  = m_last_reg;
        m_err_next   = m_err_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_char_next  = out_char;
            m_has_next   = out_has;
            m_last_next  = out_last;
            m_err_next   = out_err;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg         <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            st_reg         <= st_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg      <= code_next;
        end_reg       <= end_next;
        err_reg       <= err_next;
        pend_char_reg <= pend_char_next;
        m_char_reg    <= m_char_next;
        m_has_reg     <= m_has_next;
        m_last_reg    <= m_last_next;
        m_err_reg     <= m_err_next;
    end

    `I2P_ASSERT(a_idle_no_pending, (st_reg == ST_IDLE) |-> !pend_valid_reg,
        "A held character survived into the idle state.")
    `I2P_ASSERT(a_stall_holds, (m_valid_reg && !m_ready) |-> !out_load,
        "Result register loaded while its contents were still waiting.")

endmodule
